@@ rtl/lfuc_pkg.sv @@
// Shared types and constants for the LFU cache: the word widths, the command codes,
// the search token that walks the cell chain and the replacement write strobe.
// Has no dependencies.
`default_nettype none

package lfuc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned ENTRIES = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Search token: one word on its way along the row of cells.
  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;     // insert payload, or the value found by a lookup
    logic             found;
    logic [CNT_W-1:0] best_cnt;  // smallest use count seen so far
  } tok_t;

  // Replacement write, broadcast to all cells when the table is full.
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wr_t;

endpackage

`default_nettype wire

@@ rtl/lfuc_cell.sv @@
// One cache entry of the LFU chain: key, value and use count, plus the token stage
// that passes the search word on to the next cell. Depends on lfuc_pkg.
`default_nettype none

module lfuc_cell #(
  parameter int unsigned ENTRIES = lfuc_pkg::ENTRIES,
  parameter int unsigned IDX     = 0,
  localparam int unsigned IW     = $clog2(ENTRIES),
  localparam int unsigned CW     = $clog2(ENTRIES + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lfuc_pkg::tok_t  tok_i,
  input  wire logic [IW-1:0]   bidx_i,
  input  wire logic [CW-1:0]   fill_i,
  input  wire logic            full_i,
  input  wire lfuc_pkg::wr_t   wr_i,
  input  wire logic [IW-1:0]   wr_idx_i,
  output lfuc_pkg::tok_t       tok_o,
  output logic [IW-1:0]        bidx_o
);

  logic [lfuc_pkg::KEY_W-1:0] key_q;
  logic [lfuc_pkg::VAL_W-1:0] val_q;
  logic [lfuc_pkg::CNT_W-1:0] cnt_q;
  lfuc_pkg::tok_t             tok_q, tok_d;
  logic [IW-1:0]              bidx_q, bidx_d;

  logic filled, hit_here, ins_here, rep_here;

  assign filled   = CW'(IDX) < fill_i;
  assign hit_here = tok_i.valid && (tok_i.cmd == lfuc_pkg::CMD_LOOKUP) && filled &&
                    !tok_i.found && (key_q == tok_i.key);
  assign ins_here = tok_i.valid && (tok_i.cmd == lfuc_pkg::CMD_INSERT) && !full_i &&
                    (fill_i == CW'(IDX));
  assign rep_here = wr_i.en && (wr_idx_i == IW'(IDX));

  // Update the passing token: claim a hit, or offer this entry as victim
  always_comb begin
    tok_d  = tok_i;
    bidx_d = bidx_i;
    if (hit_here) begin
      tok_d.found = 1'b1;
      tok_d.value = val_q;
    end
    if (tok_i.valid && (tok_i.cmd == lfuc_pkg::CMD_INSERT) && filled &&
        (cnt_q < tok_i.best_cnt)) begin
      tok_d.best_cnt = cnt_q;
      bidx_d         = IW'(IDX);
    end
  end

  // Token stage towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q <= bidx_d;
  end

  // Entry storage: fill, replace, or bump the use count on a hit
  always_ff @(posedge clk_i) begin
    if (ins_here) begin
      key_q <= tok_i.key;
      val_q <= tok_i.value;
      cnt_q <= lfuc_pkg::CNT_ONE;
    end else if (rep_here) begin
      key_q <= wr_i.key;
      val_q <= wr_i.value;
      cnt_q <= lfuc_pkg::CNT_ONE;
    end else if (hit_here && (cnt_q != lfuc_pkg::CNT_MAX)) begin
      cnt_q <= cnt_q + lfuc_pkg::CNT_ONE;
    end
  end

  assign tok_o  = tok_q;
  assign bidx_o = bidx_q;

endmodule

`default_nettype wire

@@ rtl/lfu_cache_lookup_insert_top.sv @@
// Top level of the LFU cache: request control, fill counter, result register and the
// row of lfuc_cell entries. Depends on lfuc_pkg and lfuc_cell.
//
// Fully associative key/value cache with least-frequently-used replacement. A word
// with cmd 0 is a lookup and yields one result (hit and the stored value, or hit
// clear and zero); a word with cmd 1 is an insert and yields none. Inserts fill free
// entries in order with use count 1; once all ENTRIES are filled, the lowest-numbered
// entry with the smallest count is overwritten. Duplicate keys are not checked, and
// use counts saturate. Each request walks the row of entry cells one cell per clock,
// and a new word is taken only after the previous one has left the row; input stall
// stays high while a request is in the row, and also while a finished lookup result
// waits behind an earlier result that has not been taken yet. No clearing pass is
// needed after reset.
`default_nettype none

module lfu_cache_lookup_insert_top #(
  parameter int unsigned ENTRIES = lfuc_pkg::ENTRIES
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               cmd_i,
  input  wire logic signed [lfuc_pkg::KEY_W-1:0]  key_i,
  input  wire logic signed [lfuc_pkg::VAL_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic signed [lfuc_pkg::VAL_W-1:0]       found_value_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  lfuc_pkg::tok_t  chain [ENTRIES+1];
  logic [IW-1:0]   bidx  [ENTRIES+1];
  lfuc_pkg::tok_t  tail;
  lfuc_pkg::wr_t   wr;

  lfuc_pkg::state_e state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             full, accept, out_free;
  logic             ld_tail, ld_hold, cap_hold;

  logic                       out_valid_q, out_valid_d;
  logic                       out_hit_q;
  logic [lfuc_pkg::VAL_W-1:0] out_val_q;
  logic                       hold_hit_q;
  logic [lfuc_pkg::VAL_W-1:0] hold_val_q;

  assign in_stall_o = (state_q != lfuc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (fill_q == CW'(ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Launch the request word into the first cell
  always_comb begin
    chain[0].valid    = accept;
    chain[0].cmd      = cmd_i;
    chain[0].key      = key_i;
    chain[0].value    = (cmd_i == lfuc_pkg::CMD_INSERT) ? value_i : '0;
    chain[0].found    = 1'b0;
    chain[0].best_cnt = lfuc_pkg::CNT_MAX;
    bidx[0]           = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfuc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (chain[g]),
      .bidx_i   (bidx[g]),
      .fill_i   (fill_q),
      .full_i   (full),
      .wr_i     (wr),
      .wr_idx_i (bidx[ENTRIES]),
      .tok_o    (chain[g+1]),
      .bidx_o   (bidx[g+1])
    );
  end

  assign tail = chain[ENTRIES];

  // Replace the chosen victim once the word has left the row of a full table
  always_comb begin
    wr.en    = tail.valid && (tail.cmd == lfuc_pkg::CMD_INSERT) && full;
    wr.key   = tail.key;
    wr.value = tail.value;
  end

  // Advance the fill count when an insert into a free entry completes
  always_comb begin
    fill_d = fill_q;
    if (tail.valid && (tail.cmd == lfuc_pkg::CMD_INSERT) && !full) begin
      fill_d = fill_q + CW'(1);
    end
  end

  // Request control
  always_comb begin
    state_d  = state_q;
    ld_tail  = 1'b0;
    ld_hold  = 1'b0;
    cap_hold = 1'b0;
    case (state_q)
      lfuc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lfuc_pkg::ST_SCAN;
        end
      end
      lfuc_pkg::ST_SCAN: begin
        if (tail.valid) begin
          if (tail.cmd == lfuc_pkg::CMD_INSERT) begin
            state_d = lfuc_pkg::ST_IDLE;
          end else if (out_free) begin
            ld_tail = 1'b1;
            state_d = lfuc_pkg::ST_IDLE;
          end else begin
            cap_hold = 1'b1;
            state_d  = lfuc_pkg::ST_HOLD;
          end
        end
      end
      lfuc_pkg::ST_HOLD: begin
        if (out_free) begin
          ld_hold = 1'b1;
          state_d = lfuc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfuc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = ld_tail || ld_hold || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfuc_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register and the holding slot behind it
  always_ff @(posedge clk_i) begin
    if (cap_hold) begin
      hold_hit_q <= tail.found;
      hold_val_q <= tail.value;
    end
    if (ld_tail) begin
      out_hit_q <= tail.found;
      out_val_q <= tail.value;
    end else if (ld_hold) begin
      out_hit_q <= hold_hit_q;
      out_val_q <= hold_val_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign found_value_o = out_val_q;

endmodule

`default_nettype wire

@@ rtl/lfuc_checker.sv @@
// Port-level checks for the LFU cache top level, with the bind that attaches them.
// Depends on lfuc_pkg and lfu_cache_lookup_insert_top.
`default_nettype none

module lfuc_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic                               hit_o,
  input wire logic signed [lfuc_pkg::VAL_W-1:0]  found_value_o
);

  // A miss always carries a zero value
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_value_o == '0)
    else $error("miss result with non-zero value");

  // One request at a time: stall rises right after a word is taken
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is still in the row");

  // A stalled result stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // A stalled result keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hit_o) && $stable(found_value_o))
    else $error("stalled result changed");

endmodule

bind lfu_cache_lookup_insert_top lfuc_checker u_lfuc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hit_o         (hit_o),
  .found_value_o (found_value_o)
);

`default_nettype wire

@@ bench/lfu_cache_lookup_insert_checker.sv @@
// Checker for the LFU cache: watches both channels, keeps its own copy of the cache
// table and compares every result word with the oldest predicted one.
// Depends on lfuc_pkg.
`timescale 1ns / 1ps

module lfu_cache_lookup_insert_checker #(
  parameter int unsigned ENTRIES = lfuc_pkg::ENTRIES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                cmd_i,
  input  logic signed [lfuc_pkg::KEY_W-1:0]   key_i,
  input  logic signed [lfuc_pkg::VAL_W-1:0]   value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                hit_i,
  input  logic signed [lfuc_pkg::VAL_W-1:0]   found_value_i,
  output int unsigned                         errors_o,
  output int unsigned                         pending_o
);

  typedef struct packed {
    logic                              hit;
    logic signed [lfuc_pkg::VAL_W-1:0] found_value;
  } lookup_result_t;

  // Our own copy of the table
  logic [lfuc_pkg::KEY_W-1:0] cached_keys   [ENTRIES];
  logic [lfuc_pkg::VAL_W-1:0] cached_values [ENTRIES];
  logic [lfuc_pkg::CNT_W-1:0] use_counts    [ENTRIES];
  int unsigned                filled;

  lookup_result_t lookup_results_q [$];
  int unsigned    mismatches;

  // Apply one accepted word to the table; queue the result of a lookup
  task automatic cache_access(input logic cmd, input logic [lfuc_pkg::KEY_W-1:0] key,
                              input logic [lfuc_pkg::VAL_W-1:0] value);
    int unsigned                victim;
    logic [lfuc_pkg::CNT_W-1:0] least;
    lookup_result_t             res;
    if (cmd == lfuc_pkg::CMD_INSERT) begin
      if (filled < ENTRIES) begin
        victim = filled;
        filled++;
      end else begin
        // lowest-numbered entry among those with the smallest count
        victim = 0;
        least  = use_counts[0];
        for (int i = 1; i < ENTRIES; i++) begin
          if (use_counts[i] < least) begin
            least  = use_counts[i];
            victim = i;
          end
        end
      end
      cached_keys[victim]   = key;
      cached_values[victim] = value;
      use_counts[victim]    = lfuc_pkg::CNT_ONE;
    end else begin
      res = '0;
      // first matching entry wins; hold the count once it has saturated
      for (int i = 0; i < filled && !res.hit; i++) begin
        if (cached_keys[i] == key) begin
          if (use_counts[i] != lfuc_pkg::CNT_MAX) use_counts[i] = use_counts[i] + 1'b1;
          res.hit         = 1'b1;
          res.found_value = cached_values[i];
        end
      end
      lookup_results_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      filled     = 0;
      mismatches = 0;
      lookup_results_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // compare the result word taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (lookup_results_q.size() == 0) begin
          mismatches++;
          $error("result word with no lookup outstanding: hit %0b, found_value %0d",
                 hit_i, found_value_i);
        end else begin
          want = lookup_results_q.pop_front();
          if (hit_i !== want.hit) begin
            mismatches++;
            $error("hit: expected %0b, got %0b", want.hit, hit_i);
          end
          if (found_value_i !== want.found_value) begin
            mismatches++;
            $error("found_value: expected %0d, got %0d", want.found_value, found_value_i);
          end
        end
      end
      // advance the table with the word taken at this edge
      if (in_valid_i && !in_stall_i) cache_access(cmd_i, key_i, value_i);
      errors_o  <= mismatches;
      pending_o <= lookup_results_q.size();
    end
  end

endmodule

@@ bench/lfu_cache_lookup_insert_top_test.sv @@
// Top of the LFU cache testbench: clock, reset, request and stall stimulus, verdict.
// Depends on lfuc_pkg, lfu_cache_lookup_insert_top and lfu_cache_lookup_insert_checker.
`timescale 1ns / 1ps

module lfu_cache_lookup_insert_top_test;

  localparam int unsigned ENTRIES      = lfuc_pkg::ENTRIES;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
  localparam int unsigned SAT_LOOKUPS  = 8;
  localparam int unsigned POOL_SIZE    = 24;
  localparam logic [31:0] SAT_KEY      = 32'h5A5A_C3C3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              cmd = lfuc_pkg::CMD_LOOKUP;
  logic signed [lfuc_pkg::KEY_W-1:0] key = '0;
  logic signed [lfuc_pkg::VAL_W-1:0] value = '0;
  logic                              out_stall = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic                              hit;
  logic signed [lfuc_pkg::VAL_W-1:0] found_value;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] key_pool [POOL_SIZE];

  lfu_cache_lookup_insert_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .key_i         (key),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .hit_o         (hit),
    .found_value_o (found_value)
  );

  lfu_cache_lookup_insert_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .key_i         (key),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .hit_i         (hit),
    .found_value_i (found_value),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random stall on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one request word, with a random gap first, and hold it until taken
  task automatic send_word(input logic c, input logic [31:0] k, input logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Mixed lookups and inserts over a small key pool so that hits are common
  task automatic random_phase(input int unsigned n, input int unsigned idle_pct,
                              input int unsigned stall_pct);
    logic        c;
    logic [31:0] k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      c = ($urandom_range(99) < 45) ? lfuc_pkg::CMD_INSERT : lfuc_pkg::CMD_LOOKUP;
      k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      send_word(c, k, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extreme keys and values, duplicates, fill and replace
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(lfuc_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(lfuc_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(lfuc_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(lfuc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0);
    // duplicate key: the older entry must still answer
    send_word(lfuc_pkg::CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0);
    // fill the table, then replace on a tie among single-use entries
    for (int i = 0; i < ENTRIES - 5; i++) send_word(lfuc_pkg::CMD_INSERT, 32'h100 + i, $urandom);
    send_word(lfuc_pkg::CMD_INSERT, 32'hCAFE_0001, 32'h0BAD_F00D);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'hCAFE_0001, 32'h0);
    send_word(lfuc_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0);

    // Raise one use count well above the rest, then flood the table with inserts:
    // the busy entry must survive them all
    send_word(lfuc_pkg::CMD_INSERT, SAT_KEY, 32'h3C3C_5A5A);
    repeat (SAT_LOOKUPS) send_word(lfuc_pkg::CMD_LOOKUP, SAT_KEY, $urandom);
    for (int i = 0; i < ENTRIES; i++) send_word(lfuc_pkg::CMD_INSERT, 32'h0F00_0000 + i, $urandom);
    send_word(lfuc_pkg::CMD_LOOKUP, SAT_KEY, 32'h0);

    // Random: pool with the extremes plus random keys
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    random_phase(150, 0, 0);
    random_phase(150, 87, 0);
    random_phase(150, 0, 87);
    random_phase(150, 15, 15);
    in_valid <= 1'b0;

    // Let the checker count the last word, drain outstanding results, then settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
